### rtl/ffra_pkg.sv
`default_nettype none

package ffra_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_BINS_DEF   = 1024;
  localparam int SPACE_BITS_DEF = 32;

  // Fixed field and register widths.
  localparam int LEN_W  = 32;
  localparam int CAP_W  = 32;
  localparam int BIN_W  = 11;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Command codes carried on the input side band.
  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Register select, taken from bit 2 of the byte address.
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_BINS     = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DOWN,
    ST_UP,
    ST_DONE
  } ffra_state_t;

endpackage

`default_nettype wire

### rtl/first_fit_row_allocator.sv
`default_nettype none

// First-fit bin allocator. The remaining space of every bin sits in the leaves
// of a max-of-children tree held in one dual-read, single-write memory. A place
// transaction walks down the tree, one level per cycle, always taking the left
// child when it can hold the request, then writes the new leaf and the
// refreshed ancestors back up, one node per cycle. With L = clog2(MAX_BINS)
// levels, a place that finds a bin presents its result after the write-back,
// and the block returns to idle as that result enters the output register.
// A miss is decided at the level where neither child can hold the request, or
// at the leaves when the first bin that fits lies past the bin count register
// or past MAX_BINS; its result then follows without a write-back.
// A clear transaction rewrites every one of the 2*2^L memory entries at one
// entry per cycle through the single write port and presents its result after
// the sweep. The same sweep runs after reset, with in_tready low until it ends.
// One transaction is processed at a time; the result sits in an output
// register, so the next transaction is accepted while it waits, and a later
// result that finds the register still full holds off the input until it
// drains.
// A capacity write takes effect at the next clear.
module first_fit_row_allocator
  import ffra_pkg::*;
#(
  parameter int MAX_BINS   = MAX_BINS_DEF,
  parameter int SPACE_BITS = SPACE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input stream.
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [LEN_W-1:0]  in_tdata,    // [31:0] request_length
  input  wire logic              in_tuser,    // [0] command
  // Result stream.
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,   // [10:0] bin_number, [15:11] zero
  output logic                   out_tuser,   // [0] found
  // Configuration port.
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int LEVELS = $clog2(MAX_BINS);
  localparam int AW     = LEVELS + 1;
  localparam int LVL_W  = $clog2(LEVELS + 1);
  localparam int SW     = SPACE_BITS;
  localparam int CW     = (SPACE_BITS > LEN_W) ? SPACE_BITS : LEN_W;
  localparam int CMPW   = ((LEVELS > BIN_W) ? LEVELS : BIN_W) + 1;

  // Tree memory: entry 1 is the root, leaves start at 2^LEVELS.
  logic [SW-1:0] mem [2**AW];
  logic [SW-1:0] rd_l_r;
  logic [SW-1:0] rd_r_r;
  logic          rd_en;
  logic [AW-1:0] rd_node;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;

  // Sibling values met on the way down, one per level.
  logic [SW-1:0] sib_r [1:LEVELS];
  logic          sib_we;

  ffra_state_t state_r, state_nxt;

  logic [CAP_W-1:0] cap_r;
  logic [BIN_W-1:0] bins_r;
  logic [SW-1:0]    fill_r, fill_nxt;
  logic             clr_cmd_r, clr_cmd_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]    node_r, node_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [SW-1:0]    cur_val_r, cur_val_nxt;
  logic             res_found_r, res_found_nxt;
  logic [BIN_W-1:0] res_bin_r, res_bin_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [BIN_W-1:0] out_bin_r, out_bin_nxt;

  logic            in_acc;
  logic            cfg_wr;
  logic            clr_last;
  logic            left_fit;
  logic            right_fit;
  logic            any_fit;
  logic            at_leaves;
  logic [AW-1:0]   child;
  logic [SW-1:0]   chosen_val;
  logic [SW-1:0]   sib_val;
  logic [CMPW-1:0] leaf_idx;
  logic            leaf_ok;
  logic [CMPW-1:0] bin_full;
  logic            up_last;
  logic            out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign clr_last   = (clr_addr_r == {AW{1'b1}});
  assign out_free   = !out_tvalid_r || out_tready;

  // Descent decision on the two children just read.
  assign left_fit   = CW'(rd_l_r) >= CW'(len_r);
  assign right_fit  = CW'(rd_r_r) >= CW'(len_r);
  assign any_fit    = left_fit || right_fit;
  assign child      = {node_r[AW-2:0], !left_fit};
  assign chosen_val = left_fit ? rd_l_r : rd_r_r;
  assign sib_val    = left_fit ? rd_r_r : rd_l_r;
  assign at_leaves  = (lvl_r == LVL_W'(LEVELS));
  assign leaf_idx   = CMPW'(child[LEVELS-1:0]);
  assign leaf_ok    = (leaf_idx < CMPW'(bins_r)) && (leaf_idx < CMPW'(MAX_BINS));
  assign bin_full   = leaf_idx + CMPW'(1);
  assign up_last    = (lvl_r == LVL_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_cmd_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == CMD_CLEAR) ? ST_CLEAR : ST_DOWN;
        end
      end
      ST_DOWN: begin
        if (!any_fit) begin
          state_nxt = ST_DONE;
        end else if (at_leaves) begin
          state_nxt = leaf_ok ? ST_UP : ST_DONE;
        end
      end
      ST_UP: begin
        if (up_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    fill_nxt       = fill_r;
    clr_cmd_nxt    = clr_cmd_r;
    clr_addr_nxt   = clr_addr_r;
    node_nxt       = node_r;
    lvl_nxt        = lvl_r;
    len_nxt        = len_r;
    cur_val_nxt    = cur_val_r;
    res_found_nxt  = res_found_r;
    res_bin_nxt    = res_bin_r;
    out_found_nxt  = out_found_r;
    out_bin_nxt    = out_bin_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    rd_en          = 1'b0;
    rd_node        = child;
    wr_en          = 1'b0;
    wr_addr        = node_r;
    wr_data        = cur_val_r;
    sib_we         = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = fill_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      ST_IDLE: begin
        res_found_nxt = 1'b0;
        res_bin_nxt   = '0;
        len_nxt       = in_tdata;
        node_nxt      = AW'(1);
        lvl_nxt       = LVL_W'(1);
        rd_node       = AW'(1);
        if (in_acc) begin
          if (in_tuser == CMD_CLEAR) begin
            fill_nxt     = SW'(cap_r);
            clr_cmd_nxt  = 1'b1;
            clr_addr_nxt = '0;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      ST_DOWN: begin
        if (any_fit) begin
          sib_we   = 1'b1;
          node_nxt = child;
          if (at_leaves) begin
            if (leaf_ok) begin
              cur_val_nxt   = SW'(CW'(chosen_val) - CW'(len_r));
              res_found_nxt = 1'b1;
              res_bin_nxt   = bin_full[BIN_W-1:0];
            end
          end else begin
            rd_en   = 1'b1;
            lvl_nxt = lvl_r + LVL_W'(1);
          end
        end
      end
      ST_UP: begin
        wr_en       = 1'b1;
        cur_val_nxt = (cur_val_r > sib_r[lvl_r]) ? cur_val_r : sib_r[lvl_r];
        node_nxt    = node_r >> 1;
        lvl_nxt     = lvl_r - LVL_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = res_found_r;
          out_bin_nxt    = res_bin_r;
          clr_cmd_nxt    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_l_r <= mem[{rd_node[AW-2:0], 1'b0}];
      rd_r_r <= mem[{rd_node[AW-2:0], 1'b1}];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (sib_we) begin
      sib_r[lvl_r] <= sib_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cap_r        <= CAP_W'(1);
      bins_r       <= BIN_W'(1024);
      fill_r       <= SW'(1);
      clr_cmd_r    <= 1'b0;
      clr_addr_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      clr_cmd_r    <= clr_cmd_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[2])
          REG_CAPACITY: cap_r  <= cfg_pwdata;
          REG_BINS:     bins_r <= cfg_pwdata[BIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    lvl_r       <= lvl_nxt;
    len_r       <= len_nxt;
    cur_val_r   <= cur_val_nxt;
    res_found_r <= res_found_nxt;
    res_bin_r   <= res_bin_nxt;
    out_found_r <= out_found_nxt;
    out_bin_r   <= out_bin_nxt;
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_CAPACITY: cfg_prdata = cap_r;
      REG_BINS:     cfg_prdata = DATA_W'(bins_r);
      default:      cfg_prdata = '0;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {5'b0, out_bin_r};

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ffra_pkg::*;

  localparam logic [ADDR_W-1:0] CAP_ADDR  = {REG_CAPACITY, 2'b00};
  localparam logic [ADDR_W-1:0] BINS_ADDR = {REG_BINS, 2'b00};
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 55;

  typedef struct packed {
    logic             found;
    logic [BIN_W-1:0] bin_number;
  } placement_t;

  // Tracks the remaining space of every bin and the placements still owed by the block.
  class allocation_scoreboard;
    logic [LEN_W-1:0] bin_space [MAX_BINS_DEF];
    logic [CAP_W-1:0] capacity;
    logic [BIN_W-1:0] bins_searched;
    placement_t       expected_placements[$];
    int               errors;

    function new();
      capacity = 1;
      bins_searched = BIN_W'(MAX_BINS_DEF);
      foreach (bin_space[i]) bin_space[i] = 1;
      errors = 0;
    endfunction

    function void set_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
      if (addr[2] == REG_BINS) begin
        bins_searched = value[BIN_W-1:0];
      end else begin
        capacity = value[CAP_W-1:0];
      end
    endfunction

    function logic [DATA_W-1:0] register_value(logic [ADDR_W-1:0] addr);
      if (addr[2] == REG_BINS) return DATA_W'(bins_searched);
      return DATA_W'(capacity);
    endfunction

    function void accept_command(logic cmd, logic [LEN_W-1:0] len);
      placement_t p;
      int         limit;
      p = '0;
      if (cmd == CMD_CLEAR) begin
        foreach (bin_space[i]) bin_space[i] = capacity;
      end else begin
        limit = (bins_searched > MAX_BINS_DEF) ? MAX_BINS_DEF : int'(bins_searched);
        for (int i = 0; i < limit; i++) begin
          if (bin_space[i] >= len) begin
            bin_space[i] = bin_space[i] - len;
            p.found = 1'b1;
            p.bin_number = BIN_W'(i + 1);
            break;
          end
        end
      end
      expected_placements.push_back(p);
    endfunction

    function void check_placement(logic found, logic [BIN_W-1:0] bin_number);
      placement_t want;
      if (expected_placements.size() == 0) begin
        $error("unexpected result: found %0d bin_number %0d", found, bin_number);
        errors++;
        return;
      end
      want = expected_placements.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        errors++;
      end
      if (bin_number !== want.bin_number) begin
        $error("bin_number: expected %0d, actual %0d", want.bin_number, bin_number);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [LEN_W-1:0]  in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;
  logic              out_tuser;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  allocation_scoreboard alloc_sb = new();
  bit steady = 1'b0;
  bit hold_request = 1'b0;

  first_fit_row_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [31:0] request_length
    .in_tuser   (in_tuser),     // [0] command
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [10:0] bin_number, [15:11] zero
    .out_tuser  (out_tuser),    // [0] found
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= steady || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      alloc_sb.check_placement(out_tuser, out_tdata[BIN_W-1:0]);
    end
  end

  task automatic offer(input logic cmd, input logic [LEN_W-1:0] len);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= len;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    alloc_sb.accept_command(cmd, len);
  endtask

  // Stop offering and wait until every outstanding placement has come back.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (alloc_sb.expected_placements.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_access(input logic write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (write) begin
      alloc_sb.set_register(addr, value);
    end else if (cfg_prdata !== alloc_sb.register_value(addr)) begin
      $error("register %0d: expected %0h, actual %0h", addr,
             alloc_sb.register_value(addr), cfg_prdata);
      alloc_sb.errors++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    reg_access(1'b1, addr, value);
    reg_access(1'b0, addr, '0);
  endtask

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0] cap;
    logic [LEN_W-1:0] len;
    int               r;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    // The block sweeps its memory after reset; keep the registers untouched until it ends.
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    // Reset state: every bin holds one unit, all 1024 bins searched.
    offer(CMD_PLACE, 32'd1);
    offer(CMD_PLACE, 32'd1);
    offer(CMD_PLACE, 32'd0);
    offer(CMD_PLACE, 32'd2);
    offer(CMD_PLACE, 32'hFFFF_FFFF);
    settle();
    set_reg(BINS_ADDR, 32'd2);
    offer(CMD_PLACE, 32'd1);
    settle();
    set_reg(BINS_ADDR, 32'd0);
    offer(CMD_PLACE, 32'd0);
    settle();
    set_reg(BINS_ADDR, 32'd2047);
    offer(CMD_PLACE, 32'd1);
    settle();
    set_reg(BINS_ADDR, 32'd1024);
    set_reg(CAP_ADDR, 32'hFFFF_FFFF);
    // The new capacity only applies after the next clear.
    offer(CMD_PLACE, 32'd1);
    offer(CMD_CLEAR, 32'hA5A5_5A5A);
    offer(CMD_PLACE, 32'hFFFF_FFFF);
    offer(CMD_PLACE, 32'd1);
    offer(CMD_PLACE, 32'h8000_0000);
    offer(CMD_PLACE, 32'hFFFF_FFFF);
    settle();
    set_reg(CAP_ADDR, 32'd10);
    set_reg(BINS_ADDR, 32'd3);
    offer(CMD_PLACE, 32'd4);
    offer(CMD_CLEAR, 32'd0);
    repeat (4) offer(CMD_PLACE, 32'd6);
    offer(CMD_PLACE, 32'd4);
    settle();
    // Bins 4 and 5 come into the search still holding their earlier space.
    set_reg(BINS_ADDR, 32'd5);
    offer(CMD_PLACE, 32'd5);
    offer(CMD_PLACE, 32'd10);
    offer(CMD_PLACE, 32'd11);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(9))
        0:       cap = 1;
        1:       cap = 32'hFFFF_FFFF;
        2:       cap = $urandom;
        default: cap = $urandom_range(2, 64);
      endcase
      if (ph[0]) set_reg(CAP_ADDR, cap);
      case ($urandom_range(9))
        0:       set_reg(BINS_ADDR, 32'd0);
        1:       set_reg(BINS_ADDR, 32'd1024);
        2:       set_reg(BINS_ADDR, $urandom_range(1025, 2047));
        3:       set_reg(BINS_ADDR, 32'd1);
        default: set_reg(BINS_ADDR, $urandom_range(2, 24));
      endcase
      if (!ph[0]) set_reg(CAP_ADDR, cap);
      steady = (ph == 4);
      offer(CMD_CLEAR, $urandom);
      if (ph == 6) begin
        settle();
        hold_request = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph[0] && n == PHASE_ITEMS / 2) begin
          // Change the searched range without a clear.
          settle();
          set_reg(BINS_ADDR, $urandom_range(1, 40));
        end
        r = $urandom_range(99);
        if (r < 2) begin
          offer(CMD_CLEAR, $urandom);
        end else begin
          if (r < 8) len = $urandom;
          else if (r < 12) len = 0;
          else if (r < 18) len = cap;
          else if (r < 22) len = cap + 1;
          else if (cap > 16 && r < 70) len = $urandom_range(1, cap / 4);
          else len = $urandom_range(1, cap);
          offer(CMD_PLACE, len);
        end
      end
      settle();
    end
    steady = 1'b0;

    repeat (50) @(posedge clk);
    if (alloc_sb.errors == 0 && alloc_sb.expected_placements.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
